/* hdl/mscf_pkg.sv */
// ----------------------------------------------------------------------------
// Multicast source filter table package
// Shared request/result types, request and status codes, and the structs
// that travel between the controller and the group cells.
// ----------------------------------------------------------------------------
package mscf_pkg;

  // Internal source count width; covers the largest supported list length.
  localparam int CNT_W = 7;

  // Request codes.
  localparam logic [2:0] REQ_ADD_GROUP     = 3'd0;
  localparam logic [2:0] REQ_ADD_SOURCE    = 3'd1;
  localparam logic [2:0] REQ_REMOVE_SOURCE = 3'd2;
  localparam logic [2:0] REQ_CLEAR_SOURCES = 3'd3;
  localparam logic [2:0] REQ_SET_MODE      = 3'd4;
  localparam logic [2:0] REQ_ACCEPT_QUERY  = 3'd5;

  // Status codes.
  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_NO_GROUP   = 3'd1;
  localparam logic [2:0] STS_TABLE_FULL = 3'd2;
  localparam logic [2:0] STS_LIST_FULL  = 3'd3;
  localparam logic [2:0] STS_EXISTS     = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] group_addr;
    logic [31:0] source_addr;
    logic        mode_sel;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       accept;
    logic       group_mode;
    logic [4:0] list_count;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EXEC,
    ST_SCAN
  } state_t;

  // Token control broadcast to every cell.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  // Record update; only the cell holding the token applies it.
  typedef struct packed {
    logic             claim;
    logic             set_mode;
    logic             set_count;
    logic [31:0]      group;
    logic             mode;
    logic [CNT_W-1:0] count;
  } cell_wr_t;

  // Cell view, all zero unless the cell holds the token.
  typedef struct packed {
    logic             hit;
    logic             free;
    logic             mode;
    logic [CNT_W-1:0] count;
  } cell_rd_t;

endpackage

/* hdl/mscf_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mscf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* hdl/mscf_cell.sv */
// ----------------------------------------------------------------------------
// Group record cell
// Holds one group record and one stage of the search token chain.
// ----------------------------------------------------------------------------
module mscf_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mscf_pkg::cell_ctl_t  ctl,
  input  logic                 tok_in,
  input  logic [31:0]          key,
  input  mscf_pkg::cell_wr_t   wr,
  output logic                 tok_out,
  output mscf_pkg::cell_rd_t   rd
);

  logic                       tok_r;
  logic                       valid_r;
  logic [31:0]                group_r;
  logic                       mode_r;
  logic [mscf_pkg::CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (ctl.load || ctl.shift) begin
        tok_r <= tok_in;
      end
      if (tok_r && wr.claim) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_r) begin
      if (wr.claim) begin
        group_r <= wr.group;
      end
      if (wr.claim || wr.set_mode) begin
        mode_r <= wr.mode;
      end
      if (wr.claim || wr.set_count) begin
        count_r <= wr.count;
      end
    end
  end

  assign tok_out = tok_r;

  always_comb begin
    rd.hit   = tok_r && valid_r && (group_r == key);
    rd.free  = tok_r && !valid_r;
    rd.mode  = tok_r && valid_r && mode_r;
    rd.count = (tok_r && valid_r) ? count_r : '0;
  end

endmodule

/* hdl/multicast_source_filter_table_unit.sv */
// ----------------------------------------------------------------------------
// Multicast source filter table
// Group records with include/exclude mode and a bounded source list each.
// ----------------------------------------------------------------------------
//  Channel   Ports                         Transfer
//  request   start, busy, in_req           start high while busy is low
//  result    out_strobe, out_result        one cycle wide, cannot be held off
//
// A search token walks the chain of group cells one cell per cycle and stops
// at the first matching or first unused cell, at the last cell, or at once for a
// reserved code; an execute state follows. Remove and accept query then scan
// the source list in RAM at one entry per cycle, and the registered read
// drains before the answer. The result strobe comes in the same cycle that
// busy falls. Reset clears every record; no clearing pass is needed.
module multicast_source_filter_table_unit #(
  parameter int GROUPS  = 16,
  parameter int SOURCES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mscf_pkg::req_t in_req,
  output logic           out_strobe,
  output mscf_pkg::rsp_t out_result
);

  localparam int IDXW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int DEPTH = GROUPS * SOURCES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = mscf_pkg::CNT_W;

  mscf_pkg::state_t  state_r, state_nxt;
  mscf_pkg::req_t    req_r, req_nxt;
  logic [IDXW-1:0]   idx_r, idx_nxt;
  logic              found_r, found_nxt;
  logic              free_r, free_nxt;
  logic              mode_r, mode_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [CW-1:0]     rd_k_r, rd_k_nxt;
  logic [CW-1:0]     wr_w_r, wr_w_nxt;
  logic              pend_r, pend_nxt;
  logic              listed_r, listed_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  mscf_pkg::rsp_t    out_result_r, out_result_nxt;

  mscf_pkg::cell_ctl_t ctl;
  mscf_pkg::cell_wr_t  cwr;
  mscf_pkg::cell_rd_t  rd_cell [GROUPS];
  mscf_pkg::cell_rd_t  rd_any;
  logic [GROUPS-1:0]   tok;
  logic [GROUPS-1:0]   tok_in;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [31:0]       ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [31:0]       ram_rdata;
  logic              issue;
  logic [CW-1:0]     cnt_inc;

  genvar gi;
  generate
    for (gi = 0; gi < GROUPS; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign tok_in[gi] = ctl.load;
      end else begin : g_body
        assign tok_in[gi] = ctl.load ? 1'b0 : tok[gi-1];
      end
      mscf_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .tok_in  (tok_in[gi]),
        .key     (req_r.group_addr),
        .wr      (cwr),
        .tok_out (tok[gi]),
        .rd      (rd_cell[gi])
      );
    end
  endgenerate

  // Only the cell holding the token drives a nonzero view.
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < GROUPS; i++) begin
      rd_any = mscf_pkg::cell_rd_t'(rd_any | rd_cell[i]);
    end
  end

  mscf_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign issue   = (rd_k_r < cnt_r);
  assign cnt_inc = cnt_r + CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mscf_pkg::ST_IDLE;
      out_strobe_r <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    found_r      <= found_nxt;
    free_r       <= free_nxt;
    mode_r       <= mode_nxt;
    cnt_r        <= cnt_nxt;
    base_r       <= base_nxt;
    rd_k_r       <= rd_k_nxt;
    wr_w_r       <= wr_w_nxt;
    listed_r     <= listed_nxt;
    out_result_r <= out_result_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    free_nxt       = free_r;
    mode_nxt       = mode_r;
    cnt_nxt        = cnt_r;
    base_nxt       = base_r;
    rd_k_nxt       = rd_k_r;
    wr_w_nxt       = wr_w_r;
    pend_nxt       = 1'b0;
    listed_nxt     = listed_r;
    out_strobe_nxt = 1'b0;
    out_result_nxt = out_result_r;
    ctl            = '0;
    cwr            = '0;
    cwr.group      = req_r.group_addr;
    cwr.mode       = req_r.mode_sel;
    ram_we         = 1'b0;
    ram_waddr      = base_r + AW'(cnt_r);
    ram_wdata      = req_r.source_addr;
    ram_raddr      = base_r + AW'(rd_k_r);

    unique case (state_r)
      mscf_pkg::ST_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          ctl.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = mscf_pkg::ST_SEARCH;
        end
      end

      mscf_pkg::ST_SEARCH: begin
        base_nxt = AW'(32'(idx_r) * 32'(SOURCES));
        mode_nxt = rd_any.mode;
        cnt_nxt  = rd_any.count;
        if (req_r.req_type > mscf_pkg::REQ_ACCEPT_QUERY) begin
          found_nxt = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = mscf_pkg::ST_EXEC;
        end else if (rd_any.hit) begin
          found_nxt = 1'b1;
          free_nxt  = 1'b0;
          state_nxt = mscf_pkg::ST_EXEC;
        end else if (rd_any.free || idx_r == IDXW'(GROUPS - 1)) begin
          found_nxt = 1'b0;
          free_nxt  = rd_any.free;
          state_nxt = mscf_pkg::ST_EXEC;
        end else begin
          ctl.shift = 1'b1;
          idx_nxt   = idx_r + IDXW'(1);
        end
      end

      mscf_pkg::ST_EXEC: begin
        out_result_nxt = '0;
        state_nxt      = mscf_pkg::ST_IDLE;
        out_strobe_nxt = 1'b1;
        rd_k_nxt       = '0;
        wr_w_nxt       = '0;
        listed_nxt     = 1'b0;
        case (req_r.req_type) inside
          mscf_pkg::REQ_ADD_GROUP: begin
            if (found_r) begin
              out_result_nxt.status     = mscf_pkg::STS_EXISTS;
              out_result_nxt.group_mode = mode_r;
              out_result_nxt.list_count = cnt_r[4:0];
            end else if (free_r) begin
              cwr.claim                 = 1'b1;
              cwr.count                 = '0;
              out_result_nxt.status     = mscf_pkg::STS_OK;
              out_result_nxt.group_mode = req_r.mode_sel;
            end else begin
              out_result_nxt.status = mscf_pkg::STS_TABLE_FULL;
            end
          end
          mscf_pkg::REQ_ADD_SOURCE, mscf_pkg::REQ_REMOVE_SOURCE,
          mscf_pkg::REQ_CLEAR_SOURCES, mscf_pkg::REQ_SET_MODE,
          mscf_pkg::REQ_ACCEPT_QUERY: begin
            if (!found_r) begin
              out_result_nxt.status = mscf_pkg::STS_NO_GROUP;
            end else begin
              out_result_nxt.group_mode = mode_r;
              out_result_nxt.list_count = cnt_r[4:0];
              case (req_r.req_type) inside
                mscf_pkg::REQ_ADD_SOURCE: begin
                  if (cnt_r >= CW'(SOURCES)) begin
                    out_result_nxt.status = mscf_pkg::STS_LIST_FULL;
                  end else begin
                    ram_we                    = 1'b1;
                    cwr.set_count             = 1'b1;
                    cwr.count                 = cnt_inc;
                    out_result_nxt.list_count = cnt_inc[4:0];
                  end
                end
                mscf_pkg::REQ_CLEAR_SOURCES: begin
                  cwr.set_count             = 1'b1;
                  cwr.count                 = '0;
                  out_result_nxt.list_count = '0;
                end
                mscf_pkg::REQ_SET_MODE: begin
                  cwr.set_mode              = 1'b1;
                  out_result_nxt.group_mode = req_r.mode_sel;
                end
                default: begin
                  // Remove and accept query walk the list before answering.
                  out_strobe_nxt = 1'b0;
                  state_nxt      = mscf_pkg::ST_SCAN;
                end
              endcase
            end
          end
          default: begin
            // Reserved request codes answer with all fields zero.
          end
        endcase
      end

      mscf_pkg::ST_SCAN: begin
        pend_nxt = issue;
        if (issue) begin
          rd_k_nxt = rd_k_r + CW'(1);
        end
        if (pend_r) begin
          if (ram_rdata == req_r.source_addr) begin
            listed_nxt = 1'b1;
          end else if (req_r.req_type == mscf_pkg::REQ_REMOVE_SOURCE) begin
            // Kept entries slide down to the write pointer, keeping order.
            ram_we    = 1'b1;
            ram_waddr = base_r + AW'(wr_w_r);
            ram_wdata = ram_rdata;
            wr_w_nxt  = wr_w_r + CW'(1);
          end
        end
        if (!issue && !pend_r) begin
          state_nxt                 = mscf_pkg::ST_IDLE;
          out_strobe_nxt            = 1'b1;
          out_result_nxt            = '0;
          out_result_nxt.status     = mscf_pkg::STS_OK;
          out_result_nxt.group_mode = mode_r;
          if (req_r.req_type == mscf_pkg::REQ_REMOVE_SOURCE) begin
            cwr.set_count             = 1'b1;
            cwr.count                 = wr_w_r;
            out_result_nxt.list_count = wr_w_r[4:0];
          end else begin
            out_result_nxt.list_count = cnt_r[4:0];
            out_result_nxt.accept     = mode_r ? !listed_r : listed_r;
          end
        end
      end

      default: begin
        state_nxt = mscf_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != mscf_pkg::ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

endmodule
